/* rtl/core/tabx_pkg.sv */
// ----------------------------------------------------------------------------
// Tab expander package
// Shared widths, character codes, command and state types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tabx_pkg;

    localparam int BYTE_W      = 8;
    localparam int STOP_IDX_W  = 4;
    localparam int STOP_VAL_W  = 16;
    localparam int TAB_W_W     = 7;
    localparam int STOP_CNT_W  = 5;
    localparam int STATUS_W    = 2;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 7;
    localparam int TAB_N_W     = 7;
    localparam int TAB_LIMIT   = 64;
    localparam int FIFO_DEPTH  = 2;

    localparam int MAX_STOPS_DEF   = 16;
    localparam int COLUMN_BITS_DEF = 16;

    localparam logic [TAB_W_W-1:0] TAB_PITCH_RST = 7'd8;

    localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_DEL   = 8'h7F;

    localparam logic [CFG_ADDR_W-1:0] CFG_TAB_PITCH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_STOP_COUNT = 2'd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_TEXT     = 2'd0,
        ST_LOADED   = 2'd1,
        ST_REJECTED = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        K_TEXT,
        K_TAB,
        K_BACK,
        K_LINE,
        K_LOAD
    } kind_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DIV,
        B_SCAN,
        B_LOAD_CHK,
        B_ONE,
        B_EMIT
    } back_state_t;

    typedef struct packed {
        kind_t                  kind;
        logic [BYTE_W-1:0]      data_byte;
        logic [STOP_IDX_W-1:0]  stop_index;
        logic [STOP_VAL_W-1:0]  stop_value;
        logic                   idx_ok;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef struct packed {
        logic [TAB_W_W-1:0]    tab_pitch;
        logic [STOP_CNT_W-1:0] stop_count;
    } cfg_t;

endpackage

/* rtl/core/tabx_item_if.sv */
// ----------------------------------------------------------------------------
// Tab expander input channel
// Valid/ready channel carrying one text byte or one stop load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tabx_item_if;
    import tabx_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  action;
    logic [BYTE_W-1:0]     in_byte;
    logic [STOP_IDX_W-1:0] stop_index;
    logic [STOP_VAL_W-1:0] stop_value;

    modport source (
        output valid, action, in_byte, stop_index, stop_value,
        input  ready
    );

    modport sink (
        input  valid, action, in_byte, stop_index, stop_value,
        output ready
    );
endinterface

/* rtl/core/tabx_result_if.sv */
// ----------------------------------------------------------------------------
// Tab expander result channel
// Valid/ready channel carrying one emitted byte with last and status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tabx_result_if;
    import tabx_pkg::*;

    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   out_byte;
    logic                last;
    logic [STATUS_W-1:0] status;

    modport source (
        output valid, out_byte, last, status,
        input  ready
    );

    modport sink (
        input  valid, out_byte, last, status,
        output ready
    );
endinterface

/* rtl/core/tabx_cfg_if.sv */
// ----------------------------------------------------------------------------
// Tab expander configuration channel
// Valid/ready register write channel with address and data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tabx_cfg_if;
    import tabx_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, addr, data,
        input  ready
    );

    modport sink (
        input  valid, addr, data,
        output ready
    );
endinterface

/* rtl/core/tabx_ram.sv */
// ----------------------------------------------------------------------------
// Tab expander RAM
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tabx_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/tabx_fifo.sv */
// ----------------------------------------------------------------------------
// Tab expander command queue
// Short register queue between the classifier and the executor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tabx_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tabx_pkg::cmd_t      wr_cmd,
    input  logic                pop,
    output tabx_pkg::cmd_t      rd_cmd,
    output tabx_pkg::fifo_stat_t stat
);
    import tabx_pkg::*;

    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    cmd_t          entry_reg [FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    assign rd_cmd     = entry_reg[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CW'(FIFO_DEPTH));

endmodule

/* rtl/core/tabx_front.sv */
// ----------------------------------------------------------------------------
// Tab expander front end
// Accept input transfers and classify them into queue commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tabx_front #(
    parameter int MAX_STOPS = tabx_pkg::MAX_STOPS_DEF
) (
    tabx_item_if.sink            item,
    input  tabx_pkg::fifo_stat_t stat,
    output logic                 push,
    output tabx_pkg::cmd_t       cmd
);
    import tabx_pkg::*;

    assign item.ready = !stat.full;
    assign push       = item.valid && !stat.full;

    always_comb
    begin
        cmd.data_byte  = item.in_byte;
        cmd.stop_index = item.stop_index;
        cmd.stop_value = item.stop_value;
        cmd.idx_ok     = (32'(item.stop_index) < MAX_STOPS);
        if (item.action)
        begin
            cmd.kind = K_LOAD;
        end
        else if (item.in_byte == CHAR_TAB)
        begin
            cmd.kind = K_TAB;
        end
        else if (item.in_byte == CHAR_DEL)
        begin
            cmd.kind = K_BACK;
        end
        else if (item.in_byte inside {CHAR_LF, CHAR_CR})
        begin
            cmd.kind = K_LINE;
        end
        else
        begin
            cmd.kind = K_TEXT;
        end
    end

endmodule

/* rtl/core/tabx_back.sv */
// ----------------------------------------------------------------------------
// Tab expander back end
// Execute queued commands: column tracking, tab stop search, stop loads
// and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tabx_back #(
    parameter int MAX_STOPS   = tabx_pkg::MAX_STOPS_DEF,
    parameter int COLUMN_BITS = tabx_pkg::COLUMN_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  tabx_pkg::cfg_t cfg,
    input  logic           cmd_valid,
    input  tabx_pkg::cmd_t cmd,
    output logic           cmd_pop,
    tabx_result_if.source  result
);
    import tabx_pkg::*;

    localparam int AW    = $clog2(MAX_STOPS);
    localparam int CNT_W = $clog2(MAX_STOPS + 1);
    localparam int BC_W  = $clog2(COLUMN_BITS);
    localparam int CMP_W = (COLUMN_BITS > STOP_VAL_W) ? COLUMN_BITS : STOP_VAL_W;

    back_state_t            state_reg;
    back_state_t            state_next;
    cmd_t                   cmd_reg;
    cmd_t                   cmd_next;
    logic [COLUMN_BITS-1:0] column_reg;
    logic [COLUMN_BITS-1:0] column_next;
    logic [COLUMN_BITS-1:0] div_reg;
    logic [COLUMN_BITS-1:0] div_next;
    logic [TAB_N_W-1:0]     rem_reg;
    logic [TAB_N_W-1:0]     rem_next;
    logic [BC_W-1:0]        bit_cnt_reg;
    logic [BC_W-1:0]        bit_cnt_next;
    logic [AW-1:0]          scan_idx_reg;
    logic [AW-1:0]          scan_idx_next;
    logic [TAB_N_W-1:0]     spaces_reg;
    logic [TAB_N_W-1:0]     spaces_next;
    logic [BYTE_W-1:0]      pend_byte_reg;
    logic [BYTE_W-1:0]      pend_byte_next;
    status_t                pend_status_reg;
    status_t                pend_status_next;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [BYTE_W-1:0]      out_byte_reg;
    logic [BYTE_W-1:0]      out_byte_next;
    logic                   out_last_reg;
    logic                   out_last_next;
    status_t                out_status_reg;
    status_t                out_status_next;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [STOP_VAL_W-1:0]  ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [STOP_VAL_W-1:0]  ram_rdata;

    logic [TAB_N_W-1:0]     tw_eff;
    logic [CNT_W-1:0]       cnt_eff;
    logic                   out_free;
    logic                   out_load;
    logic                   start_emit;
    logic [TAB_N_W-1:0]     n_sel;
    logic [TAB_N_W:0]       shifted;
    logic [TAB_N_W:0]       rem_step;
    logic [CMP_W-1:0]       entry_ext;
    logic [CMP_W-1:0]       column_ext;
    logic [CMP_W-1:0]       gap;
    logic [STOP_VAL_W-1:0]  prev;
    logic [STOP_VAL_W-1:0]  load_gap;
    logic                   load_ok;
    logic [COLUMN_BITS:0]   col_sum;

    tabx_ram #(
        .WIDTH (STOP_VAL_W),
        .DEPTH (MAX_STOPS)
    ) u_stop_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign tw_eff   = (32'(cfg.tab_pitch) > TAB_LIMIT) ? TAB_N_W'(TAB_LIMIT) : cfg.tab_pitch;
    assign cnt_eff  = (32'(cfg.stop_count) > MAX_STOPS) ? CNT_W'(MAX_STOPS)
                                                        : CNT_W'(cfg.stop_count);
    assign out_free = !out_valid_reg || result.ready;

    assign shifted    = {rem_reg, div_reg[COLUMN_BITS-1]};
    assign rem_step   = (shifted >= {1'b0, tw_eff}) ? shifted - {1'b0, tw_eff} : shifted;
    assign entry_ext  = CMP_W'(ram_rdata);
    assign column_ext = CMP_W'(column_reg);
    assign gap        = entry_ext - column_ext;
    assign prev       = (cmd_reg.stop_index == '0) ? '0 : ram_rdata;
    assign load_gap   = cmd_reg.stop_value - prev;
    assign load_ok    = cmd_reg.idx_ok && (cmd_reg.stop_value > prev)
                        && (load_gap <= STOP_VAL_W'(TAB_LIMIT));

    assign ram_waddr = AW'(cmd_reg.stop_index);
    assign ram_wdata = cmd_reg.stop_value;

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        column_next      = column_reg;
        div_next         = div_reg;
        rem_next         = rem_reg;
        bit_cnt_next     = bit_cnt_reg;
        scan_idx_next    = scan_idx_reg;
        spaces_next      = spaces_reg;
        pend_byte_next   = pend_byte_reg;
        pend_status_next = pend_status_reg;
        out_byte_next    = out_byte_reg;
        out_last_next    = out_last_reg;
        out_status_next  = out_status_reg;
        cmd_pop          = 1'b0;
        ram_we           = 1'b0;
        ram_raddr        = '0;
        out_load         = 1'b0;
        start_emit       = 1'b0;
        n_sel            = TAB_N_W'(1);
        col_sum          = '0;

        case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop          = 1'b1;
                    cmd_next         = cmd;
                    pend_byte_next   = cmd.data_byte;
                    pend_status_next = ST_TEXT;
                    case (cmd.kind)
                        K_LOAD:
                        begin
                            ram_raddr  = AW'(cmd.stop_index - 4'd1);
                            state_next = B_LOAD_CHK;
                        end
                        K_TAB:
                        begin
                            if (tw_eff != '0)
                            begin
                                div_next     = column_reg;
                                rem_next     = '0;
                                bit_cnt_next = BC_W'(COLUMN_BITS - 1);
                                state_next   = B_DIV;
                            end
                            else if (cnt_eff == '0)
                            begin
                                start_emit = 1'b1;
                            end
                            else
                            begin
                                scan_idx_next = '0;
                                state_next    = B_SCAN;
                            end
                        end
                        K_BACK:
                        begin
                            if (column_reg != '0)
                            begin
                                column_next = column_reg - COLUMN_BITS'(1);
                            end
                            state_next = B_ONE;
                        end
                        K_LINE:
                        begin
                            column_next = '0;
                            state_next  = B_ONE;
                        end
                        default:
                        begin
                            if (!(&column_reg))
                            begin
                                column_next = column_reg + COLUMN_BITS'(1);
                            end
                            state_next = B_ONE;
                        end
                    endcase
                end
            end
            B_DIV:
            begin
                rem_next     = rem_step[TAB_N_W-1:0];
                div_next     = div_reg << 1;
                bit_cnt_next = bit_cnt_reg - BC_W'(1);
                if (bit_cnt_reg == '0)
                begin
                    n_sel      = tw_eff - rem_step[TAB_N_W-1:0];
                    start_emit = 1'b1;
                end
            end
            B_SCAN:
            begin
                ram_raddr = scan_idx_reg + AW'(1);
                if (entry_ext > column_ext)
                begin
                    n_sel      = (gap > CMP_W'(TAB_LIMIT)) ? TAB_N_W'(TAB_LIMIT)
                                                           : gap[TAB_N_W-1:0];
                    start_emit = 1'b1;
                end
                else if (CNT_W'(scan_idx_reg) == cnt_eff - CNT_W'(1))
                begin
                    start_emit = 1'b1;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + AW'(1);
                end
            end
            B_LOAD_CHK:
            begin
                ram_we           = load_ok;
                pend_byte_next   = '0;
                pend_status_next = load_ok ? ST_LOADED : ST_REJECTED;
                state_next       = B_ONE;
            end
            B_ONE:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_byte_next   = pend_byte_reg;
                    out_last_next   = 1'b1;
                    out_status_next = pend_status_reg;
                    state_next      = B_IDLE;
                end
            end
            B_EMIT:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_byte_next   = CHAR_SPACE;
                    out_last_next   = (spaces_reg == TAB_N_W'(1));
                    out_status_next = ST_TEXT;
                    spaces_next     = spaces_reg - TAB_N_W'(1);
                    if (spaces_reg == TAB_N_W'(1))
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        if (start_emit)
        begin
            col_sum     = {1'b0, column_reg} + (COLUMN_BITS + 1)'(n_sel);
            column_next = col_sum[COLUMN_BITS] ? '1 : col_sum[COLUMN_BITS-1:0];
            spaces_next = n_sel;
            state_next  = B_EMIT;
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            column_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            column_reg    <= column_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        div_reg         <= div_next;
        rem_reg         <= rem_next;
        bit_cnt_reg     <= bit_cnt_next;
        scan_idx_reg    <= scan_idx_next;
        spaces_reg      <= spaces_next;
        pend_byte_reg   <= pend_byte_next;
        pend_status_reg <= pend_status_next;
        out_byte_reg    <= out_byte_next;
        out_last_reg    <= out_last_next;
        out_status_reg  <= out_status_next;
    end

    assign result.valid    = out_valid_reg;
    assign result.out_byte = out_byte_reg;
    assign result.last     = out_last_reg;
    assign result.status   = out_status_reg;

endmodule

/* rtl/core/tab_expander_core.sv */
// ----------------------------------------------------------------------------
// Tab expander core
// Text byte: B_IDLE pops it, B_ONE loads the result register when it is free;
// one item at a time. Stop load: B_IDLE starts the registered stop RAM read,
// B_LOAD_CHK checks and writes, B_ONE emits the status. Tab, fixed width: B_DIV
// gets the remainder bit-serially, then B_EMIT sends one space per cycle while
// the output is free; stop table tab: one stop per cycle via the RAM read port.
// Reset: column 0, tab width 8, stop count 0, queue empty; stop RAM not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tab_expander_core #(
    parameter int MAX_STOPS   = tabx_pkg::MAX_STOPS_DEF,
    parameter int COLUMN_BITS = tabx_pkg::COLUMN_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    tabx_item_if.sink     item,
    tabx_result_if.source result,
    tabx_cfg_if.sink      cfg
);
    import tabx_pkg::*;

    cfg_t       cfg_reg;
    fifo_stat_t fifo_stat;
    logic       cmd_push;
    logic       cmd_pop;
    cmd_t       push_cmd;
    cmd_t       head_cmd;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tab_pitch  <= TAB_PITCH_RST;
            cfg_reg.stop_count <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.addr)
                CFG_TAB_PITCH:  cfg_reg.tab_pitch  <= cfg.data[TAB_W_W-1:0];
                CFG_STOP_COUNT: cfg_reg.stop_count <= cfg.data[STOP_CNT_W-1:0];
                default:        ;
            endcase
        end
    end

    tabx_front #(
        .MAX_STOPS (MAX_STOPS)
    ) u_front (
        .item (item),
        .stat (fifo_stat),
        .push (cmd_push),
        .cmd  (push_cmd)
    );

    tabx_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (cmd_push),
        .wr_cmd (push_cmd),
        .pop    (cmd_pop),
        .rd_cmd (head_cmd),
        .stat   (fifo_stat)
    );

    tabx_back #(
        .MAX_STOPS   (MAX_STOPS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (!fifo_stat.empty),
        .cmd       (head_cmd),
        .cmd_pop   (cmd_pop),
        .result    (result)
    );

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !fifo_stat.full)
        else $error("command pushed into a full queue");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !fifo_stat.empty)
        else $error("command popped from an empty queue");

    a_accept_push: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |-> cmd_push)
        else $error("input transfer not queued");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.valid && cfg.ready && cfg.addr == CFG_TAB_PITCH)
        |=> (cfg_reg.tab_pitch == $past(cfg.data[TAB_W_W-1:0])))
        else $error("tab width write lost");

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Tab expander testbench
// Drives text bytes and tab stop loads into tab_expander_core with random
// gaps on both channels, predicts emitted bytes (most directed rows type
// theirs) from an internal copy of the column, registers and stop table,
// checks in order. A short directed script covers field extremes, stop load
// rejection, long tabs; random phases follow over several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import tabx_pkg::*;

    localparam int COL_MAX     = (1 << COLUMN_BITS_DEF) - 1;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam int RAMP_TABS   = 8;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 20;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_CFG,
        ROW_RAMP
    } row_kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic              last;
        status_t           st;
    } emit_t;

    typedef struct packed {
        row_kind_t             kind;
        logic                  action;
        logic [BYTE_W-1:0]     ch;
        logic [STOP_IDX_W-1:0] idx;
        logic [STOP_VAL_W-1:0] val;
        logic [CFG_ADDR_W-1:0] sel;
        int                    n_typed;
        status_t               st_typed;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    tabx_item_if   in_ch ();
    tabx_result_if out_ch ();
    tabx_cfg_if    cfg_ch ();

    tab_expander_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (in_ch),
        .result (out_ch),
        .cfg    (cfg_ch)
    );

    always #5 clk = ~clk;

    logic [TAB_W_W-1:0]    p_tab_pitch;
    logic [STOP_CNT_W-1:0] p_stop_count;
    int unsigned           p_column;
    logic [STOP_VAL_W-1:0] p_stops [MAX_STOPS_DEF];
    bit                    p_stop_set [MAX_STOPS_DEF];
    emit_t                 due_bytes [$];

    bit          rush;
    bit          hold_req;
    int          errors;
    int          shown;
    int unsigned cycles;

    function automatic int stop_limit();
        return (p_stop_count > MAX_STOPS_DEF) ? MAX_STOPS_DEF : int'(p_stop_count);
    endfunction

    // true when a tab now would only read stop entries that hold a value
    function automatic bit stop_search_known();
        int i;
        if (p_tab_pitch != 0)
            return 1'b1;
        for (i = 0; i < stop_limit(); i++)
        begin
            if (!p_stop_set[i])
                return 1'b0;
            if (p_stops[i] > p_column)
                return 1'b1;
        end
        return 1'b1;
    endfunction

    task automatic expand_item(input logic action, input logic [BYTE_W-1:0] ch,
                               input logic [STOP_IDX_W-1:0] idx,
                               input logic [STOP_VAL_W-1:0] val, input bit keep);
        int unsigned prev;
        int unsigned n;
        int unsigned w;
        int          i;
        emit_t       e;
        e.ch   = ch;
        e.last = 1'b1;
        e.st   = ST_TEXT;
        if (action)
        begin
            prev = 0;
            if (idx != 0)
                prev = p_stops[idx-1];
            e.ch = '0;
            e.st = ST_REJECTED;
            if (val > prev && val - prev <= TAB_LIMIT)
            begin
                p_stops[idx]    = val;
                p_stop_set[idx] = 1'b1;
                e.st            = ST_LOADED;
            end
            if (keep)
                due_bytes.push_back(e);
        end
        else if (ch == CHAR_TAB)
        begin
            n = 1;
            if (p_tab_pitch != 0)
            begin
                w = (p_tab_pitch > TAB_LIMIT) ? TAB_LIMIT : p_tab_pitch;
                n = w - (p_column % w);
            end
            else
            begin
                for (i = 0; i < stop_limit(); i++)
                begin
                    if (p_stops[i] > p_column)
                    begin
                        n = p_stops[i] - p_column;
                        break;
                    end
                end
                if (n > TAB_LIMIT)
                    n = TAB_LIMIT;
            end
            p_column = (COL_MAX - p_column < n) ? COL_MAX : p_column + n;
            e.ch = CHAR_SPACE;
            for (i = 0; i < n; i++)
            begin
                e.last = (i == n - 1);
                if (keep)
                    due_bytes.push_back(e);
            end
        end
        else
        begin
            if (ch == CHAR_DEL)
            begin
                if (p_column > 0)
                    p_column--;
            end
            else if (ch == CHAR_LF || ch == CHAR_CR)
                p_column = 0;
            else if (p_column < COL_MAX)
                p_column++;
            if (keep)
                due_bytes.push_back(e);
        end
    endtask

    task automatic offer_item(input logic action, input logic [BYTE_W-1:0] ch,
                              input logic [STOP_IDX_W-1:0] idx,
                              input logic [STOP_VAL_W-1:0] val);
        int gap;
        gap = rush ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8));
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.action     <= action;
        in_ch.in_byte    <= ch;
        in_ch.stop_index <= idx;
        in_ch.stop_value <= val;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic drain_output();
        in_ch.valid <= 1'b0;
        while (due_bytes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] sel,
                             input logic [CFG_DATA_W-1:0] data);
        drain_output();
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= sel;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (sel == CFG_TAB_PITCH)
            p_tab_pitch = data;
        else
            p_stop_count = data[STOP_CNT_W-1:0];
    endtask

    task automatic load_stop_ladder(input int count);
        int unsigned           prev;
        int                    i;
        logic [STOP_VAL_W-1:0] val;
        prev = 0;
        for (i = 0; i < count; i++)
        begin
            val = STOP_VAL_W'(prev + $urandom_range(1, TAB_LIMIT));
            offer_item(1'b1, BYTE_W'($urandom_range(0, 255)), STOP_IDX_W'(i), val);
            expand_item(1'b1, '0, STOP_IDX_W'(i), val, 1'b1);
            prev = val;
        end
    endtask

    task automatic random_item();
        int                    pick;
        int unsigned           prev;
        logic                  action;
        logic [BYTE_W-1:0]     ch;
        logic [STOP_IDX_W-1:0] idx;
        logic [STOP_VAL_W-1:0] val;
        action = 1'b0;
        ch     = BYTE_W'($urandom_range(0, 255));
        idx    = STOP_IDX_W'($urandom_range(0, MAX_STOPS_DEF - 1));
        val    = STOP_VAL_W'($urandom_range(0, 65535));
        pick   = $urandom_range(0, 99);
        if (pick < 35)
            ch = CHAR_TAB;
        else if (pick < 42)
            ch = ($urandom_range(0, 1) != 0) ? CHAR_LF : CHAR_CR;
        else if (pick < 48)
            ch = CHAR_DEL;
        else if (pick < 62)
        begin
            action = 1'b1;
            while (idx != 0 && !p_stop_set[idx-1])
                idx--;
            prev = 0;
            if (idx != 0)
                prev = p_stops[idx-1];
            case ($urandom_range(0, 5))
                0: val = STOP_VAL_W'(prev);
                1: val = STOP_VAL_W'(prev + TAB_LIMIT + 1 + $urandom_range(0, 200));
                2: ;
                default: val = STOP_VAL_W'(prev + $urandom_range(1, TAB_LIMIT));
            endcase
        end
        if (!action && ch == CHAR_TAB && !stop_search_known())
            ch = 8'h2E;
        offer_item(action, ch, idx, val);
        expand_item(action, ch, idx, val, 1'b1);
    endtask

    function automatic stim_row_t text_row(input logic [BYTE_W-1:0] ch, input int n);
        stim_row_t r;
        r          = '0;
        r.kind     = ROW_ITEM;
        r.ch       = ch;
        r.n_typed  = n;
        r.st_typed = ST_TEXT;
        return r;
    endfunction

    function automatic stim_row_t load_row(input logic [STOP_IDX_W-1:0] idx,
                                           input logic [STOP_VAL_W-1:0] val,
                                           input status_t st);
        stim_row_t r;
        r          = '0;
        r.kind     = ROW_ITEM;
        r.action   = 1'b1;
        r.idx      = idx;
        r.val      = val;
        r.n_typed  = 1;
        r.st_typed = st;
        return r;
    endfunction

    function automatic stim_row_t reg_row(input logic [CFG_ADDR_W-1:0] sel, input int data);
        stim_row_t r;
        r      = '0;
        r.kind = ROW_CFG;
        r.sel  = sel;
        r.val  = STOP_VAL_W'(data);
        return r;
    endfunction

    function automatic stim_row_t ramp_row(input int n);
        stim_row_t r;
        r      = '0;
        r.kind = ROW_RAMP;
        r.val  = STOP_VAL_W'(n);
        return r;
    endfunction

    initial
    begin
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            int wait_n;
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            wait_n = rush ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8));
            if (wait_n > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    always @(posedge clk)
    begin
        emit_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (due_bytes.size() == 0)
            begin
                errors++;
                if (shown < 10)
                begin
                    shown++;
                    $display("%0t unexpected transfer: byte %02h last %0b status %0d",
                             $realtime, out_ch.out_byte, out_ch.last, out_ch.status);
                end
            end
            else
            begin
                want = due_bytes.pop_front();
                if (out_ch.out_byte !== want.ch || out_ch.last !== want.last ||
                    out_ch.status !== want.st)
                begin
                    errors++;
                    if (shown < 10)
                    begin
                        shown++;
                        $display("%0t mismatch: got byte %02h last %0b status %0d, want byte %02h last %0b status %0d",
                                 $realtime, out_ch.out_byte, out_ch.last, out_ch.status,
                                 want.ch, want.last, want.st);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        stim_row_t  script [$];
        stim_row_t  row;
        emit_t      e;
        int         k;
        int         ph;
        int         tw;
        int         sc;

        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.action     = 1'b0;
        in_ch.in_byte    = '0;
        in_ch.stop_index = '0;
        in_ch.stop_value = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.addr      = CFG_TAB_PITCH;
        cfg_ch.data      = '0;
        rush             = 1'b0;
        hold_req         = 1'b0;
        errors           = 0;
        shown            = 0;
        cycles           = 0;
        p_tab_pitch      = TAB_PITCH_RST;
        p_stop_count     = '0;
        p_column         = 0;
        for (k = 0; k < MAX_STOPS_DEF; k++)
        begin
            p_stops[k]    = '0;
            p_stop_set[k] = 1'b0;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        script.push_back(text_row(8'h41, 1));
        script.push_back(text_row(CHAR_TAB, 7));
        script.push_back(text_row(CHAR_TAB, 8));
        script.push_back(text_row(CHAR_DEL, 1));
        script.push_back(text_row(CHAR_LF, 1));
        script.push_back(text_row(CHAR_DEL, 1));
        script.push_back(text_row(8'hFF, 1));
        script.push_back(text_row(8'h00, 1));
        script.push_back(text_row(CHAR_CR, 1));
        script.push_back(load_row(0, 0, ST_REJECTED));
        script.push_back(load_row(0, 65, ST_REJECTED));
        script.push_back(load_row(0, 64, ST_LOADED));
        script.push_back(load_row(1, 64, ST_REJECTED));
        script.push_back(load_row(1, 128, ST_LOADED));
        script.push_back(load_row(2, 193, ST_REJECTED));
        script.push_back(load_row(2, 192, ST_LOADED));
        script.push_back(load_row(1, 65, ST_LOADED));
        script.push_back(reg_row(CFG_TAB_PITCH, 0));
        script.push_back(reg_row(CFG_STOP_COUNT, 3));
        script.push_back(text_row(CHAR_TAB, 64));
        script.push_back(text_row(CHAR_TAB, 1));
        script.push_back(text_row(CHAR_TAB, 0));
        script.push_back(text_row(CHAR_TAB, 0));
        script.push_back(text_row(CHAR_TAB, 0));
        script.push_back(reg_row(CFG_TAB_PITCH, 127));
        script.push_back(text_row(CHAR_TAB, 0));
        script.push_back(ramp_row(RAMP_TABS));
        script.push_back(text_row(8'h7A, 1));
        script.push_back(text_row(CHAR_DEL, 1));
        script.push_back(text_row(CHAR_TAB, 0));
        script.push_back(text_row(CHAR_LF, 1));

        foreach (script[r])
        begin
            row = script[r];
            case (row.kind)
                ROW_CFG:
                    write_reg(row.sel, row.val[CFG_DATA_W-1:0]);
                ROW_RAMP:
                begin
                    rush = 1'b1;
                    repeat (row.val)
                    begin
                        offer_item(1'b0, CHAR_TAB, STOP_IDX_W'($urandom_range(0, 15)),
                                   STOP_VAL_W'($urandom_range(0, 65535)));
                        expand_item(1'b0, CHAR_TAB, '0, '0, 1'b1);
                    end
                    rush = 1'b0;
                end
                default:
                begin
                    offer_item(row.action, row.ch, row.idx, row.val);
                    expand_item(row.action, row.ch, row.idx, row.val, row.n_typed == 0);
                    e.ch = row.action ? 8'h00 : ((row.ch == CHAR_TAB) ? CHAR_SPACE : row.ch);
                    e.st = row.st_typed;
                    for (k = 0; k < row.n_typed; k++)
                    begin
                        e.last = (k == row.n_typed - 1);
                        due_bytes.push_back(e);
                    end
                end
            endcase
        end

        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: begin tw = 0;   sc = 16; end
                1: begin tw = 0;   sc = 31; end
                2: begin tw = 1;   sc = $urandom_range(0, 31); end
                3: begin tw = 127; sc = 0; end
                4: begin tw = 0;   sc = 0; end
                5: begin tw = $urandom_range(2, 63); sc = $urandom_range(0, 31); end
                6: begin tw = 0;   sc = $urandom_range(1, 16); end
                default: begin tw = 64; sc = 16; end
            endcase
            write_reg(CFG_TAB_PITCH, CFG_DATA_W'(tw));
            write_reg(CFG_STOP_COUNT, CFG_DATA_W'(sc));
            rush = (ph == 5) || ($urandom_range(0, 3) == 0);
            if (tw == 0 && sc != 0)
                load_stop_ladder((sc >= MAX_STOPS_DEF) ? MAX_STOPS_DEF : $urandom_range(1, sc));
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (ph == 2 && k == 4)
                    hold_req = 1'b1;
                if (ph == 6 && k == 15)
                    drain_output();
                random_item();
            end
        end

        rush = 1'b0;
        drain_output();
        repeat (64) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
